### rtl/ffseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flipbook frame sequencer package
// Shared transfer types, action and result codes, and sequencer states.
// ----------------------------------------------------------------------------
package ffseq_pkg;

  localparam logic [2:0] ACT_WRITE  = 3'd0;
  localparam logic [2:0] ACT_DEFINE = 3'd1;
  localparam logic [2:0] ACT_SET    = 3'd2;
  localparam logic [2:0] ACT_TICK   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic [1:0] KIND_CHANGED = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;

  localparam int RES_LIMIT = 16;
  localparam int RES_CW    = $clog2(RES_LIMIT + 1);

  localparam int DIV_W  = 8;
  localparam int REM_CW = $clog2(DIV_W + 1);

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         slot;
    logic [4:0]         frame_number;
    logic [14:0]        frame_duration;
    logic signed [15:0] frame_texture;
    logic [14:0]        target_texture;
    logic [5:0]         frame_count;
    logic [7:0]         requested_frame;
    logic               use_requested;
    logic               frozen;
    logic [7:0]         ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         result_slot;
    logic [14:0]        driven_texture;
    logic signed [15:0] shown_texture;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } out_push_t;

  typedef struct packed {
    logic [14:0]        duration;
    logic signed [15:0] texture;
  } frame_word_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] remainder;
  } rem_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_WR,
    ST_DEF_WR,
    ST_FULL,
    ST_TICK_RD,
    ST_TICK_EVAL,
    ST_TICK_MOD,
    ST_TICK_LOAD,
    ST_TICK_END
  } state_t;

endpackage

### rtl/flipbook_frame_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flipbook frame sequencer
// Animation table with frame store, tick walk and a registered result port.
// ----------------------------------------------------------------------------
// Commands enter on cmd with cmd_valid and cmd_stall; a transfer happens at a
// rising edge with cmd_valid high and cmd_stall low. Results leave on res with
// res_valid and res_stall in the same way, and the last result of a command
// carries last set. Write frame, set control and clear all give no result.
// A write frame or clear all is done on transfer, and a set control then
// writes the slot. A define reads frame 0, writes the slot and registers its
// result. A tick reads and evaluates each slot in turn; a slot that does not
// change needs no frame store read, a timed frame change reloads from the
// frame store, and a requested frame change first goes through a bit-serial
// remainder unit of 8 steps. The slot table has one read and one write port.
// The output register holds one result, so a new command is taken while a
// result waits. When the receiver stalls, the walk pauses at the next result.
// Reset empties the table and the output register; frame store contents are
// left as they were and must be written before use.
// ----------------------------------------------------------------------------
module flipbook_frame_sequencer_top #(
  parameter int MAX_ANIMS       = 16,
  parameter int FRAMES_PER_ANIM = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  ffseq_pkg::in_item_t  cmd,
  output logic                 res_valid,
  input  logic                 res_stall,
  output ffseq_pkg::out_item_t res
);

  localparam int SW  = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
  localparam int FW  = (FRAMES_PER_ANIM > 1) ? $clog2(FRAMES_PER_ANIM) : 1;
  localparam int FAW = SW + FW;

  ffseq_pkg::out_push_t   push;
  logic                   out_space;
  logic                   fs_we;
  logic [FAW-1:0]         fs_waddr;
  ffseq_pkg::frame_word_t fs_wdata;
  logic                   fs_re;
  logic [FAW-1:0]         fs_raddr;
  ffseq_pkg::frame_word_t fs_rdata;
  ffseq_pkg::rem_req_t    rem_req;
  ffseq_pkg::rem_rsp_t    rem_rsp;

  ffseq_ctrl #(
    .MAX_ANIMS       (MAX_ANIMS),
    .FRAMES_PER_ANIM (FRAMES_PER_ANIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .push      (push),
    .out_space (out_space),
    .fs_we     (fs_we),
    .fs_waddr  (fs_waddr),
    .fs_wdata  (fs_wdata),
    .fs_re     (fs_re),
    .fs_raddr  (fs_raddr),
    .fs_rdata  (fs_rdata),
    .rem_req   (rem_req),
    .rem_rsp   (rem_rsp)
  );

  ffseq_frame_store #(
    .ADDR_W (FAW)
  ) u_frame_store (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (fs_re),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  ffseq_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  assign out_space = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push.valid) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      res <= push.item;
    end
  end

endmodule

### rtl/ffseq_frame_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame store
// Single write, single read synchronous memory of frame words, registered read.
// ----------------------------------------------------------------------------
module ffseq_frame_store #(
  parameter int ADDR_W = 9
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [ADDR_W-1:0]      waddr,
  input  ffseq_pkg::frame_word_t wdata,
  input  logic                   re,
  input  logic [ADDR_W-1:0]      raddr,
  output ffseq_pkg::frame_word_t rdata
);

  ffseq_pkg::frame_word_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ffseq_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring bit-serial remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ffseq_rem (
  input  logic                clk,
  input  logic                rst,
  input  ffseq_pkg::rem_req_t req,
  output ffseq_pkg::rem_rsp_t rsp
);

  localparam int W = ffseq_pkg::DIV_W;

  logic                          busy;
  logic [ffseq_pkg::REM_CW-1:0]  count;
  logic [W-1:0]                  num;
  logic [W-1:0]                  divisor;
  logic [W-1:0]                  rem;
  logic                          done;
  logic [W:0]                    trial;

  assign trial = {rem, num[W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= ffseq_pkg::REM_CW'(W);
      end else if (busy) begin
        count <= count - ffseq_pkg::REM_CW'(1);
        if (count == ffseq_pkg::REM_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      num <= num << 1;
      if (trial >= {1'b0, divisor}) begin
        rem <= W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[W-1:0];
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

### rtl/ffseq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer control
// Holds the animation table memory and walks it for each tick.
// ----------------------------------------------------------------------------
module ffseq_ctrl #(
  parameter int MAX_ANIMS       = 16,
  parameter int FRAMES_PER_ANIM = 32,
  localparam int SW             = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1,
  localparam int FW             = (FRAMES_PER_ANIM > 1) ? $clog2(FRAMES_PER_ANIM) : 1,
  localparam int FAW            = SW + FW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  ffseq_pkg::in_item_t    cmd,
  output ffseq_pkg::out_push_t   push,
  input  logic                   out_space,
  output logic                   fs_we,
  output logic [FAW-1:0]         fs_waddr,
  output ffseq_pkg::frame_word_t fs_wdata,
  output logic                   fs_re,
  output logic [FAW-1:0]         fs_raddr,
  input  ffseq_pkg::frame_word_t fs_rdata,
  output ffseq_pkg::rem_req_t    rem_req,
  input  ffseq_pkg::rem_rsp_t    rem_rsp
);

  localparam int NW  = $clog2(FRAMES_PER_ANIM + 1);
  localparam int ACW = $clog2(MAX_ANIMS + 1);
  localparam int RCW = ffseq_pkg::RES_CW;

  typedef struct packed {
    logic [14:0]        target;
    logic [NW-1:0]      frames;
    logic [FW-1:0]      current;
    logic signed [15:0] countdown;
    logic [7:0]         request;
    logic               frozen;
    logic               use_req;
  } anim_t;

  anim_t anim_mem [MAX_ANIMS];
  anim_t anim_rdata;
  logic  anim_re;
  logic  anim_we;
  logic [SW-1:0] anim_raddr;
  logic [SW-1:0] anim_waddr;
  anim_t anim_wdata;

  ffseq_pkg::state_t state;
  ffseq_pkg::state_t state_next;

  ffseq_pkg::in_item_t  cmd_q;
  ffseq_pkg::out_item_t held;
  ffseq_pkg::out_item_t held_next;
  logic                 held_valid;
  logic                 held_valid_next;
  logic [ACW-1:0]       active_count;
  logic [ACW-1:0]       active_count_next;
  logic [ACW-1:0]       idx;
  logic [ACW-1:0]       idx_next;
  logic [RCW-1:0]       nres;
  logic [RCW-1:0]       nres_next;
  anim_t                cur;
  anim_t                cur_next;

  logic                 full;
  logic                 set_ok;
  logic [SW-1:0]        def_slot;
  logic [NW-1:0]        def_frames;
  logic                 req_change;
  logic signed [16:0]   cd_diff;
  logic signed [15:0]   cd_sat;
  logic [NW-1:0]        cur_inc;
  logic [FW-1:0]        wrap;
  logic                 tick_go;
  logic                 res_cap;
  anim_t                def_entry;
  anim_t                set_entry;

  assign cmd_stall = (state != ffseq_pkg::ST_IDLE);

  // Shared decode used by both the next-state and the output logic.
  always_comb begin
    full     = (32'(active_count) >= MAX_ANIMS);
    set_ok   = (32'(cmd.slot) < 32'(active_count));
    def_slot = active_count[SW-1:0];
    if (32'(cmd_q.frame_count) > FRAMES_PER_ANIM) begin
      def_frames = NW'(FRAMES_PER_ANIM);
    end else begin
      def_frames = NW'(cmd_q.frame_count);
    end
    req_change = anim_rdata.use_req && (anim_rdata.request != 8'(anim_rdata.current));
    cd_diff    = {anim_rdata.countdown[15], anim_rdata.countdown} - {9'd0, cmd_q.ticks};
    if (cd_diff[16] && !cd_diff[15]) begin
      cd_sat = 16'sh8000;
    end else begin
      cd_sat = cd_diff[15:0];
    end
    cur_inc = NW'(anim_rdata.current) + NW'(1);
    if (cur_inc == anim_rdata.frames) begin
      wrap = '0;
    end else begin
      wrap = FW'(cur_inc);
    end
    res_cap = (nres == RCW'(ffseq_pkg::RES_LIMIT));
    tick_go = res_cap || !held_valid || out_space;

    def_entry.target  = cmd_q.target_texture;
    def_entry.frames  = def_frames;
    def_entry.current = '0;
    def_entry.request = '0;
    def_entry.frozen  = 1'b0;
    def_entry.use_req = 1'b0;
    if (def_frames != '0) begin
      def_entry.countdown = {1'b0, fs_rdata.duration};
    end else begin
      def_entry.countdown = '0;
    end

    set_entry         = anim_rdata;
    set_entry.request = cmd_q.requested_frame;
    set_entry.use_req = cmd_q.use_requested;
    set_entry.frozen  = cmd_q.frozen;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ffseq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.action)
            ffseq_pkg::ACT_DEFINE: begin
              state_next = full ? ffseq_pkg::ST_FULL : ffseq_pkg::ST_DEF_WR;
            end
            ffseq_pkg::ACT_SET: begin
              if (set_ok) begin
                state_next = ffseq_pkg::ST_SET_WR;
              end
            end
            ffseq_pkg::ACT_TICK: begin
              state_next = ffseq_pkg::ST_TICK_RD;
            end
            default: begin
              state_next = ffseq_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ffseq_pkg::ST_SET_WR: begin
        state_next = ffseq_pkg::ST_IDLE;
      end
      ffseq_pkg::ST_DEF_WR, ffseq_pkg::ST_FULL: begin
        if (out_space) begin
          state_next = ffseq_pkg::ST_IDLE;
        end
      end
      ffseq_pkg::ST_TICK_RD: begin
        if (idx == active_count) begin
          state_next = ffseq_pkg::ST_TICK_END;
        end else begin
          state_next = ffseq_pkg::ST_TICK_EVAL;
        end
      end
      ffseq_pkg::ST_TICK_EVAL: begin
        priority if (anim_rdata.frames == '0) begin
          state_next = ffseq_pkg::ST_TICK_RD;
        end else if (req_change) begin
          state_next = ffseq_pkg::ST_TICK_MOD;
        end else if (!anim_rdata.frozen && cd_sat[15]) begin
          state_next = ffseq_pkg::ST_TICK_LOAD;
        end else begin
          state_next = ffseq_pkg::ST_TICK_RD;
        end
      end
      ffseq_pkg::ST_TICK_MOD: begin
        if (rem_rsp.done) begin
          state_next = ffseq_pkg::ST_TICK_LOAD;
        end
      end
      ffseq_pkg::ST_TICK_LOAD: begin
        if (tick_go) begin
          state_next = ffseq_pkg::ST_TICK_RD;
        end
      end
      ffseq_pkg::ST_TICK_END: begin
        if (!held_valid || out_space) begin
          state_next = ffseq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffseq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    anim_re    = 1'b0;
    anim_raddr = idx[SW-1:0];
    anim_we    = 1'b0;
    anim_waddr = idx[SW-1:0];
    anim_wdata = cur;
    fs_we      = 1'b0;
    fs_waddr   = {SW'(cmd.slot), FW'(cmd.frame_number)};
    fs_wdata   = {cmd.frame_duration, cmd.frame_texture};
    fs_re      = 1'b0;
    fs_raddr   = {idx[SW-1:0], cur.current};
    rem_req.start    = 1'b0;
    rem_req.dividend = anim_rdata.request;
    rem_req.divisor  = 8'(anim_rdata.frames);
    push.valid = 1'b0;
    push.item  = held;
    active_count_next = active_count;
    idx_next          = idx;
    nres_next         = nres;
    held_next         = held;
    held_valid_next   = held_valid;
    cur_next          = cur;

    unique case (state)
      ffseq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.action)
            ffseq_pkg::ACT_WRITE: begin
              fs_we = (32'(cmd.slot) < MAX_ANIMS) &&
                      (32'(cmd.frame_number) < FRAMES_PER_ANIM);
            end
            ffseq_pkg::ACT_DEFINE: begin
              fs_re    = !full;
              fs_raddr = {def_slot, FW'(0)};
            end
            ffseq_pkg::ACT_SET: begin
              anim_re    = set_ok;
              anim_raddr = SW'(cmd.slot);
            end
            ffseq_pkg::ACT_TICK: begin
              idx_next        = '0;
              nres_next       = '0;
              held_valid_next = 1'b0;
            end
            ffseq_pkg::ACT_CLEAR: begin
              active_count_next = '0;
            end
            default: begin
              fs_we = 1'b0;
            end
          endcase
        end
      end
      ffseq_pkg::ST_SET_WR: begin
        anim_we    = 1'b1;
        anim_waddr = SW'(cmd_q.slot);
        anim_wdata = set_entry;
      end
      ffseq_pkg::ST_DEF_WR: begin
        anim_waddr = def_slot;
        anim_wdata = def_entry;
        push.item.kind           = ffseq_pkg::KIND_ACK;
        push.item.result_slot    = 4'(def_slot);
        push.item.driven_texture = cmd_q.target_texture;
        push.item.shown_texture  = (def_frames != '0) ? fs_rdata.texture : 16'shFFFF;
        push.item.last           = 1'b1;
        if (out_space) begin
          anim_we           = 1'b1;
          push.valid        = 1'b1;
          active_count_next = active_count + ACW'(1);
        end
      end
      ffseq_pkg::ST_FULL: begin
        push.valid = out_space;
        push.item  = '{kind: ffseq_pkg::KIND_FULL, result_slot: '0, driven_texture: '0,
                       shown_texture: '0, last: 1'b1};
      end
      ffseq_pkg::ST_TICK_RD: begin
        anim_re = (idx != active_count);
      end
      ffseq_pkg::ST_TICK_EVAL: begin
        cur_next = anim_rdata;
        priority if (anim_rdata.frames == '0) begin
          idx_next = idx + ACW'(1);
        end else if (req_change) begin
          rem_req.start = 1'b1;
        end else if (!anim_rdata.frozen) begin
          cur_next.countdown = cd_sat;
          if (cd_sat[15]) begin
            cur_next.current = wrap;
            fs_re            = 1'b1;
            fs_raddr         = {idx[SW-1:0], wrap};
          end else begin
            anim_we  = 1'b1;
            idx_next = idx + ACW'(1);
          end
        end else begin
          idx_next = idx + ACW'(1);
        end
        anim_wdata = cur_next;
      end
      ffseq_pkg::ST_TICK_MOD: begin
        if (rem_rsp.done) begin
          cur_next.request = rem_rsp.remainder;
          cur_next.current = FW'(rem_rsp.remainder);
          fs_re            = 1'b1;
          fs_raddr         = {idx[SW-1:0], FW'(rem_rsp.remainder)};
        end
      end
      ffseq_pkg::ST_TICK_LOAD: begin
        anim_wdata           = cur;
        anim_wdata.countdown = {1'b0, fs_rdata.duration};
        if (tick_go) begin
          anim_we  = 1'b1;
          idx_next = idx + ACW'(1);
          if (!res_cap) begin
            push.valid      = held_valid;
            held_valid_next = 1'b1;
            held_next       = '{kind: ffseq_pkg::KIND_CHANGED, result_slot: 4'(idx[SW-1:0]),
                                driven_texture: cur.target,
                                shown_texture: fs_rdata.texture, last: 1'b0};
            nres_next       = nres + RCW'(1);
          end
        end
      end
      ffseq_pkg::ST_TICK_END: begin
        push.item.last = 1'b1;
        if (held_valid && out_space) begin
          push.valid      = 1'b1;
          held_valid_next = 1'b0;
        end
      end
      default: begin
        push.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ffseq_pkg::ST_IDLE;
      active_count <= '0;
      idx          <= '0;
      nres         <= '0;
      held_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      active_count <= active_count_next;
      idx          <= idx_next;
      nres         <= nres_next;
      held_valid   <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ffseq_pkg::ST_IDLE && cmd_valid) begin
      cmd_q <= cmd;
    end
    held <= held_next;
    cur  <= cur_next;
  end

  always_ff @(posedge clk) begin
    if (anim_we) begin
      anim_mem[anim_waddr] <= anim_wdata;
    end
    if (anim_re) begin
      anim_rdata <= anim_mem[anim_raddr];
    end
  end

endmodule

### rtl/ffseq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flipbook frame sequencer checker
// Port-level properties of the sequencer, attached to the top level.
// ----------------------------------------------------------------------------
module ffseq_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 cmd_valid,
  input logic                 cmd_stall,
  input ffseq_pkg::in_item_t  cmd,
  input logic                 res_valid,
  input logic                 res_stall,
  input ffseq_pkg::out_item_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == ffseq_pkg::KIND_FULL |->
      res.result_slot == 4'd0 && res.driven_texture == 15'd0 &&
      res.shown_texture == 16'sd0 && res.last)
    else $error("table full result is not a single zero result");

  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == ffseq_pkg::KIND_ACK |-> res.last)
    else $error("define acknowledge is not the last result");

  a_define_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && cmd.action == ffseq_pkg::ACT_DEFINE |=> cmd_stall)
    else $error("define transfer did not hold off the next command");

  a_write_fast: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && cmd.action == ffseq_pkg::ACT_WRITE |=> !cmd_stall)
    else $error("write frame held off the next command");

endmodule

bind flipbook_frame_sequencer_top ffseq_checker u_ffseq_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
